### rtl/core/gtpd_pkg.sv
// Shared types, widths and constants of the green trace peak detector.
package gtpd_pkg;

  // Field widths
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned FPS_W    = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Divider: dividend wide enough for frame_count * sweep_width, divisor for frames_per_sweep
  localparam int unsigned DIV_W = FRAME_W + COL_W;
  localparam int unsigned DSR_W = FPS_W;

  // Signed window position, wide enough for any column index plus wrap
  localparam int unsigned POS_W = 14;

  // Column store epoch tag; tag zero never matches a live epoch
  localparam int unsigned EPOCH_W = 6;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam int unsigned ENT_W = EPOCH_W + ROW_W;

  // Queue between front and back
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [FRAME_W-1:0] PEAK_GAP  = FRAME_W'(5);
  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  localparam int unsigned MAX_COLUMNS_DEF   = 1024;
  localparam int unsigned WINDOW_RADIUS_DEF = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GREEN_MARGIN     = 3'd0,
    CFG_ROW_FIRST        = 3'd1,
    CFG_ROW_LAST         = 3'd2,
    CFG_BASE_ROW         = 3'd3,
    CFG_PEAK_LEVEL       = 3'd4,
    CFG_SWEEP_START      = 3'd5,
    CFG_SWEEP_WIDTH      = 3'd6,
    CFG_FRAMES_PER_SWEEP = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] green_margin;
    logic [ROW_W-1:0]  row_first;
    logic [ROW_W-1:0]  row_last;
    logic [ROW_W-1:0]  base_row;
    logic [ROW_W-1:0]  peak_level;
    logic [COL_W-1:0]  sweep_start;
    logic [COL_W-1:0]  sweep_width;
    logic [FPS_W-1:0]  frames_per_sweep;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    green_margin:     CHAN_W'(28),
    row_first:        ROW_W'(500),
    row_last:         ROW_W'(550),
    base_row:         ROW_W'(600),
    peak_level:       ROW_W'(50),
    sweep_start:      COL_W'(66),
    sweep_width:      COL_W'(722),
    frames_per_sweep: FPS_W'(244)
  };

  typedef enum logic {
    ITEM_TRACE = 1'b0,
    ITEM_EOF   = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e       kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } queue_item_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_RUN,
    BK_DIV_Q,
    BK_DIV_R,
    BK_WIN,
    BK_WIN_TAIL,
    BK_EMIT
  } back_state_e;

endpackage

### rtl/core/green_trace_peak_detector_top.sv
// Top level of the green trace peak detector: configuration registers and wiring.
//
// Input channel (in_valid_i / in_stall_o): one beat per pixel (mode_i = 0) or one
// end-of-frame marker (mode_i = 1). A beat is taken when valid is high and stall low.
// Pixels sustain one beat per cycle; a four-entry queue parts intake from the store.
// Output channel (out_valid_o / out_stall_i): one result beat per end-of-frame marker,
// none per pixel. Results come in input order.
// An end-of-frame marker occupies the back part for two passes of the
// one-bit-per-cycle divider, then one column-store read per window column; pixels
// queued behind it wait for that. The column store is tagged with a 6-bit frame
// epoch; after reset, and after every 63rd end of frame when the epoch wraps, a
// clearing pass writes every column-store entry and in_stall_o stays high throughout.
// When the receiver stalls, the result stays in the output register; the back part
// then holds in front of the next result and the queue fills until intake stalls.
// Configuration (cfg_valid_i / cfg_ready_o, always ready) is to be written only while
// idle; this binds the user, and the block itself does not enforce it.
module green_trace_peak_detector_top #(
  parameter int unsigned MaxColumns   = gtpd_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned WindowRadius = gtpd_pkg::WINDOW_RADIUS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [gtpd_pkg::ROW_W-1:0]      pixel_row_i,
  input  logic [gtpd_pkg::COL_W-1:0]      pixel_col_i,
  input  logic [gtpd_pkg::CHAN_W-1:0]     blue_i,
  input  logic [gtpd_pkg::CHAN_W-1:0]     green_i,
  input  logic [gtpd_pkg::CHAN_W-1:0]     red_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gtpd_pkg::FRAME_W-1:0]    frame_number_o,
  output logic [gtpd_pkg::COL_W-1:0]      sweep_column_o,
  output logic                            peak_seen_o,
  output logic                            peak_recorded_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gtpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gtpd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  gtpd_pkg::cfg_t        cfg_q, cfg_d;
  gtpd_pkg::queue_item_t push_item, head;
  logic                  push, full, pop, head_vld, clearing;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (gtpd_pkg::cfg_idx_e'(cfg_index_i))
        gtpd_pkg::CFG_GREEN_MARGIN:     cfg_d.green_margin     = cfg_data_i[7:0];
        gtpd_pkg::CFG_ROW_FIRST:        cfg_d.row_first        = cfg_data_i[9:0];
        gtpd_pkg::CFG_ROW_LAST:         cfg_d.row_last         = cfg_data_i[9:0];
        gtpd_pkg::CFG_BASE_ROW:         cfg_d.base_row         = cfg_data_i[9:0];
        gtpd_pkg::CFG_PEAK_LEVEL:       cfg_d.peak_level       = cfg_data_i[9:0];
        gtpd_pkg::CFG_SWEEP_START:      cfg_d.sweep_start      = cfg_data_i[9:0];
        gtpd_pkg::CFG_SWEEP_WIDTH:      cfg_d.sweep_width      = cfg_data_i[9:0];
        gtpd_pkg::CFG_FRAMES_PER_SWEEP: cfg_d.frames_per_sweep = cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gtpd_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gtpd_front #(
    .MaxColumns (MaxColumns)
  ) u_front (
    .mode_i      (mode_i),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .blue_i      (blue_i),
    .green_i     (green_i),
    .red_i       (red_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .clearing_i  (clearing),
    .push_o      (push),
    .item_o      (push_item)
  );

  gtpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .head_vld_o  (head_vld),
    .head_o      (head)
  );

  gtpd_back #(
    .MaxColumns   (MaxColumns),
    .WindowRadius (WindowRadius)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_vld_i      (head_vld),
    .head_i          (head),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_number_o  (frame_number_o),
    .sweep_column_o  (sweep_column_o),
    .peak_seen_o     (peak_seen_o),
    .peak_recorded_o (peak_recorded_o)
  );

endmodule

### rtl/core/gtpd_fifo.sv
// Short queue of classified items between the front and back parts.
module gtpd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gtpd_pkg::queue_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 head_vld_o,
  output gtpd_pkg::queue_item_t head_o
);

  gtpd_pkg::queue_item_t store_q [gtpd_pkg::QUEUE_DEPTH];

  logic [gtpd_pkg::QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [gtpd_pkg::QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [gtpd_pkg::QUEUE_AW:0]   count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o     = (count_q == (gtpd_pkg::QUEUE_AW+1)'(gtpd_pkg::QUEUE_DEPTH));
  assign head_vld_o = (count_q != '0);
  assign head_o     = store_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_vld_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/core/gtpd_front.sv
// Front part: takes input beats, tests pixels for trace and queues work for the back part.
module gtpd_front #(
  parameter int unsigned MaxColumns = gtpd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                         mode_i,
  input  logic [gtpd_pkg::ROW_W-1:0]   pixel_row_i,
  input  logic [gtpd_pkg::COL_W-1:0]   pixel_col_i,
  input  logic [gtpd_pkg::CHAN_W-1:0]  blue_i,
  input  logic [gtpd_pkg::CHAN_W-1:0]  green_i,
  input  logic [gtpd_pkg::CHAN_W-1:0]  red_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gtpd_pkg::cfg_t               cfg_i,
  input  logic                         full_i,
  input  logic                         clearing_i,
  output logic                         push_o,
  output gtpd_pkg::queue_item_t        item_o
);

  logic [gtpd_pkg::CHAN_W:0] green_x, blue_lim, red_lim;
  logic                      row_ok, col_ok, colour_ok, is_trace, is_eof;

  // green - blue >= margin and green - red >= margin, done without going negative
  assign green_x  = {1'b0, green_i};
  assign blue_lim = {1'b0, blue_i} + {1'b0, cfg_i.green_margin};
  assign red_lim  = {1'b0, red_i} + {1'b0, cfg_i.green_margin};

  assign colour_ok = (green_x >= blue_lim) && (green_x >= red_lim);
  assign row_ok    = (pixel_row_i >= cfg_i.row_first) && (pixel_row_i <= cfg_i.row_last);
  assign col_ok    = (32'(pixel_col_i) < MaxColumns);
  assign is_eof    = mode_i;
  assign is_trace  = !mode_i && row_ok && col_ok && colour_ok;

  assign in_stall_o = full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o && (is_eof || is_trace);

  always_comb begin
    item_o.kind = is_eof ? gtpd_pkg::ITEM_EOF : gtpd_pkg::ITEM_TRACE;
    item_o.row  = pixel_row_i;
    item_o.col  = pixel_col_i;
  end

endmodule

### rtl/core/gtpd_div.sv
// Restoring divider, one quotient bit per cycle.
module gtpd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gtpd_pkg::DIV_W-1:0] dividend_i,
  input  logic [gtpd_pkg::DSR_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [gtpd_pkg::DIV_W-1:0] quot_o,
  output logic [gtpd_pkg::DSR_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(gtpd_pkg::DIV_W);

  logic                       busy_q, done_q;
  logic [CntW-1:0]            cnt_q;
  logic [gtpd_pkg::DIV_W-1:0] quot_q;
  logic [gtpd_pkg::DSR_W-1:0] rem_q, dsr_q;
  logic [gtpd_pkg::DSR_W:0]   shifted, diff;
  logic                       ge;

  assign shifted = {rem_q, quot_q[gtpd_pkg::DIV_W-1]};
  assign ge      = (shifted >= {1'b0, dsr_q});
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(gtpd_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[gtpd_pkg::DIV_W-2:0], ge};
      rem_q  <= ge ? diff[gtpd_pkg::DSR_W-1:0] : shifted[gtpd_pkg::DSR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### rtl/core/gtpd_back.sv
// Back part: column minimum store, end-of-frame sweep and window check, result register.
module gtpd_back #(
  parameter int unsigned MaxColumns   = gtpd_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned WindowRadius = gtpd_pkg::WINDOW_RADIUS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gtpd_pkg::cfg_t               cfg_i,
  input  logic                         head_vld_i,
  input  gtpd_pkg::queue_item_t        head_i,
  output logic                         pop_o,
  output logic                         clearing_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gtpd_pkg::FRAME_W-1:0] frame_number_o,
  output logic [gtpd_pkg::COL_W-1:0]   sweep_column_o,
  output logic                         peak_seen_o,
  output logic                         peak_recorded_o
);

  localparam int unsigned ColW = $clog2(MaxColumns);
  localparam int unsigned KW   = $clog2(2 * WindowRadius + 2);
  localparam logic [KW-1:0]   KLast   = KW'(2 * WindowRadius);
  localparam logic [ColW-1:0] ColLast = ColW'(MaxColumns - 1);
  localparam int unsigned RW = gtpd_pkg::ROW_W;
  localparam int unsigned PW = gtpd_pkg::POS_W;

  // ---------------------------------------------------------------- state
  gtpd_pkg::back_state_e state_q, state_d;

  logic [ColW-1:0]                 clr_cnt_q;
  logic [gtpd_pkg::EPOCH_W-1:0]    epoch_q;
  logic [gtpd_pkg::FRAME_W-1:0]    frame_cnt_q, last_peak_q;
  logic                            have_peak_q;
  logic [gtpd_pkg::COL_W:0]        centre_q;
  logic [KW-1:0]                   win_k_q;
  logic                            seen_q;

  // pixel read-modify-write pipeline
  logic            w_vld_q, fwd_vld_q;
  logic [ColW-1:0] w_col_q, fwd_col_q;
  logic [RW-1:0]   w_row_q, fwd_row_q;
  logic            chk_vld_q;

  // result register
  logic                         out_vld_q, out_seen_q, out_rec_q;
  logic [gtpd_pkg::FRAME_W-1:0] out_frame_q;
  logic [gtpd_pkg::COL_W-1:0]   out_col_q;

  // column store
  logic [gtpd_pkg::ENT_W-1:0] mem_q [MaxColumns];
  logic [gtpd_pkg::ENT_W-1:0] rd_q, wr_data;
  logic [ColW-1:0]            rd_addr, wr_addr;
  logic                       rd_en, wr_en;

  // control
  logic pop, pix_rd, div_start, div_second, win_issue, emit, clr_we, out_free;
  logic epoch_wrap;

  // ---------------------------------------------------------------- divider
  logic [gtpd_pkg::COL_W-1:0] width_eff;
  logic [gtpd_pkg::FPS_W-1:0] fps_eff;
  logic [gtpd_pkg::DIV_W-1:0] product, div_dividend, div_quot;
  logic [gtpd_pkg::DSR_W-1:0] div_divisor, div_rem;
  logic                       div_done;

  assign width_eff = (cfg_i.sweep_width == '0) ? gtpd_pkg::COL_W'(1) : cfg_i.sweep_width;
  assign fps_eff   = (cfg_i.frames_per_sweep == '0) ? gtpd_pkg::FPS_W'(1)
                                                    : cfg_i.frames_per_sweep;
  assign product   = gtpd_pkg::DIV_W'(frame_cnt_q) * gtpd_pkg::DIV_W'(width_eff);

  assign div_dividend = div_second ? div_quot : product;
  assign div_divisor  = div_second ? gtpd_pkg::DSR_W'(width_eff) : fps_eff;

  gtpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------- window position
  logic signed [PW-1:0] pos_raw, pos_w, lo_s, hi_s, w_s, max_s;
  logic                 pos_ok;

  assign lo_s    = PW'(cfg_i.sweep_start);
  assign w_s     = PW'(width_eff);
  assign hi_s    = lo_s + w_s;
  assign max_s   = PW'(MaxColumns);
  assign pos_raw = PW'(centre_q) + PW'(win_k_q) - PW'(WindowRadius);

  always_comb begin
    if (pos_raw < lo_s) begin
      pos_w = pos_raw + w_s;
    end else if (pos_raw >= hi_s) begin
      pos_w = pos_raw - w_s;
    end else begin
      pos_w = pos_raw;
    end
  end

  assign pos_ok = (pos_w >= 0) && (pos_w < max_s);

  // ---------------------------------------------------------------- pixel update
  logic [RW-1:0] rd_row, eff_min, chk_min;
  logic          tag_hit, fwd_hit, pix_we, hit;

  assign rd_row  = rd_q[RW-1:0];
  assign tag_hit = (rd_q[gtpd_pkg::ENT_W-1:RW] == epoch_q);
  assign fwd_hit = fwd_vld_q && (fwd_col_q == w_col_q);
  assign eff_min = fwd_hit ? fwd_row_q : (tag_hit ? rd_row : cfg_i.base_row);
  assign pix_we  = w_vld_q && (w_row_q < eff_min);

  // window check on the registered read
  assign chk_min = tag_hit ? rd_row : cfg_i.base_row;
  assign hit     = (cfg_i.base_row >= chk_min) &&
                   ((cfg_i.base_row - chk_min) >= cfg_i.peak_level);

  // ---------------------------------------------------------------- peak decision
  logic [gtpd_pkg::FRAME_W-1:0] gap;
  logic                         rec;

  assign gap        = frame_cnt_q - last_peak_q;
  assign rec        = seen_q && (!have_peak_q || (gap > gtpd_pkg::PEAK_GAP));
  assign out_free   = !out_vld_q || !out_stall_i;
  assign epoch_wrap = (epoch_q == gtpd_pkg::EPOCH_LAST);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtpd_pkg::BK_CLEAR: begin
        if (clr_cnt_q == ColLast) state_d = gtpd_pkg::BK_RUN;
      end
      gtpd_pkg::BK_RUN: begin
        if (head_vld_i && head_i.kind == gtpd_pkg::ITEM_EOF) state_d = gtpd_pkg::BK_DIV_Q;
      end
      gtpd_pkg::BK_DIV_Q: begin
        if (div_done) state_d = gtpd_pkg::BK_DIV_R;
      end
      gtpd_pkg::BK_DIV_R: begin
        if (div_done) state_d = gtpd_pkg::BK_WIN;
      end
      gtpd_pkg::BK_WIN: begin
        if (win_k_q == KLast) state_d = gtpd_pkg::BK_WIN_TAIL;
      end
      gtpd_pkg::BK_WIN_TAIL: begin
        state_d = gtpd_pkg::BK_EMIT;
      end
      gtpd_pkg::BK_EMIT: begin
        if (out_free) state_d = epoch_wrap ? gtpd_pkg::BK_CLEAR : gtpd_pkg::BK_RUN;
      end
      default: begin
        state_d = gtpd_pkg::BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    div_start  = 1'b0;
    div_second = 1'b0;
    win_issue  = 1'b0;
    emit       = 1'b0;
    clr_we     = 1'b0;
    unique case (state_q)
      gtpd_pkg::BK_CLEAR: begin
        clr_we = 1'b1;
      end
      gtpd_pkg::BK_RUN: begin
        pop       = head_vld_i;
        div_start = head_vld_i && head_i.kind == gtpd_pkg::ITEM_EOF;
      end
      gtpd_pkg::BK_DIV_Q: begin
        div_second = 1'b1;
        div_start  = div_done;
      end
      gtpd_pkg::BK_WIN: begin
        win_issue = 1'b1;
      end
      gtpd_pkg::BK_EMIT: begin
        emit = out_free;
      end
      gtpd_pkg::BK_DIV_R, gtpd_pkg::BK_WIN_TAIL: begin
      end
      default: begin
      end
    endcase
  end

  assign pix_rd     = pop && head_i.kind == gtpd_pkg::ITEM_TRACE;
  assign pop_o      = pop;
  assign clearing_o = (state_q == gtpd_pkg::BK_CLEAR);

  // ---------------------------------------------------------------- memory ports
  assign rd_en   = pix_rd || (win_issue && pos_ok);
  assign rd_addr = win_issue ? pos_w[ColW-1:0] : ColW'(head_i.col);
  assign wr_en   = clr_we || pix_we;
  assign wr_addr = clr_we ? clr_cnt_q : w_col_q;
  assign wr_data = clr_we ? '0 : {epoch_q, w_row_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gtpd_pkg::BK_CLEAR;
      clr_cnt_q   <= '0;
      epoch_q     <= gtpd_pkg::EPOCH_FIRST;
      frame_cnt_q <= '0;
      last_peak_q <= '0;
      have_peak_q <= 1'b0;
      w_vld_q     <= 1'b0;
      fwd_vld_q   <= 1'b0;
      chk_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      win_k_q     <= '0;
      seen_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      w_vld_q   <= pix_rd;
      fwd_vld_q <= pix_we;
      chk_vld_q <= win_issue && pos_ok;

      if (clr_we) begin
        clr_cnt_q <= (clr_cnt_q == ColLast) ? '0 : clr_cnt_q + 1'b1;
      end

      if (state_q == gtpd_pkg::BK_DIV_R && div_done) begin
        win_k_q <= '0;
        seen_q  <= 1'b0;
      end else begin
        if (win_issue) win_k_q <= win_k_q + 1'b1;
        if (chk_vld_q && hit) seen_q <= 1'b1;
      end

      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      if (emit) begin
        if (rec) begin
          have_peak_q <= 1'b1;
          last_peak_q <= frame_cnt_q;
        end
        if (frame_cnt_q != gtpd_pkg::FRAME_MAX) frame_cnt_q <= frame_cnt_q + 1'b1;
        epoch_q <= epoch_wrap ? gtpd_pkg::EPOCH_FIRST : epoch_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    w_col_q   <= ColW'(head_i.col);
    w_row_q   <= head_i.row;
    fwd_col_q <= w_col_q;
    fwd_row_q <= w_row_q;
    if (state_q == gtpd_pkg::BK_DIV_R && div_done) begin
      centre_q <= (gtpd_pkg::COL_W+1)'(div_rem[gtpd_pkg::COL_W-1:0]) +
                  (gtpd_pkg::COL_W+1)'(cfg_i.sweep_start);
    end
    if (emit) begin
      out_frame_q <= frame_cnt_q;
      out_col_q   <= centre_q[gtpd_pkg::COL_W-1:0];
      out_seen_q  <= seen_q;
      out_rec_q   <= rec;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign frame_number_o  = out_frame_q;
  assign sweep_column_o  = out_col_q;
  assign peak_seen_o     = out_seen_q;
  assign peak_recorded_o = out_rec_q;

  // ---------------------------------------------------------------- assertions
  a_clear_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gtpd_pkg::BK_CLEAR) |-> (!w_vld_q && !pop))
    else $error("pixel update in flight during clearing pass");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == gtpd_pkg::BK_DIV_Q || state_q == gtpd_pkg::BK_DIV_R))
    else $error("divider finished with no division pending");

  a_window_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_issue |-> (!w_vld_q && !fwd_vld_q))
    else $error("window read overlaps a pixel update");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch tag reached the cleared value");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_vld_q)
    else $error("result lost on its way to the output register");

endmodule
